// ===== design/aapr_pkg.sv =====
// ----------------------------------------------------------------------------
// aapr_pkg
// Shared constants, types and rounding helper of the axis-align point rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package aapr_pkg;

  localparam int COORD_W   = 32;
  localparam int AXIS_W    = 32;
  localparam int UNIT_FRAC = 30;
  localparam int MAT_FRAC  = ((62 - COORD_W) < 30) ? (62 - COORD_W) : 30;
  localparam int MAT_W     = MAT_FRAC + 2;
  localparam int ACC_W     = 64;
  localparam int NUM_AXIS  = 6;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OPPOSITE  = 2'd1;
  localparam logic [1:0] ST_ZERO_AXIS = 2'd2;
  localparam logic [1:0] ST_SATURATED = 2'd3;

  typedef logic [NUM_AXIS-1:0][AXIS_W-1:0] aapr_axis_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [8:0][MAT_W-1:0] m;
  } aapr_mat_t;

  // divide by 2^s, round half away from zero
  function automatic logic signed [ACC_W-1:0] rnd_shift(input logic signed [ACC_W-1:0] v,
                                                        input int s);
    logic [ACC_W-1:0] mg;
    logic [ACC_W-1:0] r;
    mg = v[ACC_W-1] ? (~v + 1'b1) : v;
    if (s == 0) begin
      r = mg;
    end else begin
      r = (mg + (ACC_W'(1) << (s - 1))) >> s;
    end
    return v[ACC_W-1] ? $signed(~r + 1'b1) : $signed(r);
  endfunction

endpackage

`default_nettype wire

// ===== design/aapr_div.sv =====
// ----------------------------------------------------------------------------
// aapr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module aapr_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [aapr_pkg::ACC_W-1:0] num,
  input  wire logic [31:0]               den,
  output logic                           done,
  output logic [aapr_pkg::ACC_W-1:0]     quot
);
  import aapr_pkg::*;

  localparam int CNT_W = $clog2(ACC_W + 1);

  logic [ACC_W-1:0] qn_r;
  logic [31:0]      rem_r;
  logic [31:0]      den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;
  logic [32:0]      sh;
  logic             ge;

  assign sh   = {rem_r, qn_r[ACC_W-1]};
  assign ge   = sh >= {1'b0, den_r};
  assign done = done_r;
  assign quot = qn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        qn_r  <= num;
        rem_r <= '0;
        den_r <= den;
        cnt_r <= CNT_W'(ACC_W);
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= ge ? 32'(sh - {1'b0, den_r}) : sh[31:0];
        qn_r  <= {qn_r[ACC_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/aapr_mat_build.sv =====
// ----------------------------------------------------------------------------
// aapr_mat_build
// Sequencer that normalizes both axes and builds the rotation matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module aapr_mat_build (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 go,
  input  wire aapr_pkg::aapr_axis_t axis,
  output logic                      busy,
  output aapr_pkg::aapr_mat_t       mat
);
  import aapr_pkg::*;

  localparam int VEC_W = 34;
  localparam logic signed [VEC_W:0]   ONE_V = (VEC_W+1)'(1 << UNIT_FRAC);
  localparam logic signed [ACC_W-1:0] ONE_E = ACC_W'(1 << UNIT_FRAC);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ_MUL, S_SQ_ACC, S_SQRT, S_U_GO, S_U_WAIT,
    S_DOT_MUL, S_DOT_ACC, S_ENT_MUL, S_ENT_GO, S_ENT_WAIT
  } state_t;

  state_t                  state_r;
  logic                    busy_r;
  aapr_mat_t               mat_r;
  logic                    ax_r;
  logic [1:0]              comp_r;
  logic [ACC_W-1:0]        len2_r;
  logic [ACC_W-1:0]        x_r;
  logic [ACC_W-1:0]        root_r;
  logic [ACC_W-1:0]        bit_r;
  logic [4:0]              cnt_r;
  logic [31:0]             len_r;
  logic signed [31:0]      u1_r [3];
  logic signed [31:0]      u2_r [3];
  logic signed [ACC_W-1:0] acc_r;
  logic [3:0]              t_r;
  logic signed [VEC_W-1:0] c_r;
  logic signed [VEC_W-1:0] v_r [3];
  logic [3:0]              e_r;
  logic signed [ACC_W-1:0] prod_r;

  logic [2:0]                aidx;
  logic [AXIS_W-1:0]         raw;
  logic [AXIS_W-1:0]         amag;
  logic signed [VEC_W-1:0]   mul_a;
  logic signed [VEC_W-1:0]   mul_b;
  logic signed [2*VEC_W-1:0] mul_p;
  logic [1:0]                di;
  logic [1:0]                dj;
  logic                      dneg;
  logic [1:0]                ei;
  logic [1:0]                ej;
  logic signed [VEC_W-1:0]   aterm;
  logic signed [VEC_W:0]     d_w;
  logic [ACC_W-1:0]          pmag;
  logic                      div_start;
  logic [ACC_W-1:0]          div_num;
  logic                      div_done;
  logic [ACC_W-1:0]          div_quot;
  logic [ACC_W-1:0]          len2_sum;
  logic [ACC_W-1:0]          root_bit;
  logic signed [ACC_W-1:0]   dot_sum;
  logic signed [ACC_W-1:0]   dot_rnd;
  logic signed [ACC_W-1:0]   ent_q;
  logic signed [ACC_W-1:0]   ent_e;
  logic signed [ACC_W-1:0]   ent_c;
  logic signed [ACC_W-1:0]   ent_m;

  assign aidx = ax_r ? (3'(comp_r) + 3'd3) : 3'(comp_r);
  assign raw  = axis[aidx];
  assign amag = raw[AXIS_W-1] ? (~raw + 1'b1) : raw;
  assign d_w  = ONE_V + (VEC_W+1)'(c_r);
  assign pmag = prod_r[ACC_W-1] ? ACC_W'(-prod_r) : prod_r;

  always_comb begin
    case (t_r)
      4'd0:    begin di = 2'd0; dj = 2'd0; dneg = 1'b0; end
      4'd1:    begin di = 2'd1; dj = 2'd1; dneg = 1'b0; end
      4'd2:    begin di = 2'd2; dj = 2'd2; dneg = 1'b0; end
      4'd3:    begin di = 2'd1; dj = 2'd2; dneg = 1'b0; end
      4'd4:    begin di = 2'd2; dj = 2'd1; dneg = 1'b1; end
      4'd5:    begin di = 2'd2; dj = 2'd0; dneg = 1'b0; end
      4'd6:    begin di = 2'd0; dj = 2'd2; dneg = 1'b1; end
      4'd7:    begin di = 2'd0; dj = 2'd1; dneg = 1'b0; end
      default: begin di = 2'd1; dj = 2'd0; dneg = 1'b1; end
    endcase
  end

  always_comb begin
    case (e_r)
      4'd0:    begin ei = 2'd0; ej = 2'd0; aterm = c_r;      end
      4'd1:    begin ei = 2'd0; ej = 2'd1; aterm = -v_r[2]; end
      4'd2:    begin ei = 2'd0; ej = 2'd2; aterm = v_r[1];  end
      4'd3:    begin ei = 2'd1; ej = 2'd0; aterm = v_r[2];  end
      4'd4:    begin ei = 2'd1; ej = 2'd1; aterm = c_r;     end
      4'd5:    begin ei = 2'd1; ej = 2'd2; aterm = -v_r[0]; end
      4'd6:    begin ei = 2'd2; ej = 2'd0; aterm = -v_r[1]; end
      4'd7:    begin ei = 2'd2; ej = 2'd1; aterm = v_r[0];  end
      default: begin ei = 2'd2; ej = 2'd2; aterm = c_r;     end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQ_MUL: begin
        mul_a = $signed(VEC_W'(amag));
        mul_b = $signed(VEC_W'(amag));
      end
      S_DOT_MUL: begin
        mul_a = VEC_W'(u1_r[di]);
        mul_b = VEC_W'(u2_r[dj]);
      end
      S_ENT_MUL: begin
        mul_a = v_r[ei];
        mul_b = v_r[ej];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign div_start = (state_r == S_U_GO) || (state_r == S_ENT_GO);
  assign div_num   = (state_r == S_U_GO)
                   ? ((ACC_W'(amag) << UNIT_FRAC) + ACC_W'(len_r[31:1]))
                   : (pmag + ACC_W'(d_w[31:1]));

  aapr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   ((state_r == S_U_GO) ? len_r : d_w[31:0]),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign len2_sum = len2_r + ACC_W'(prod_r);
  assign root_bit = root_r + bit_r;
  assign dot_sum  = acc_r + (dneg ? -prod_r : prod_r);
  assign dot_rnd  = rnd_shift(dot_sum, UNIT_FRAC);
  assign ent_q    = prod_r[ACC_W-1] ? -$signed(div_quot) : $signed(div_quot);
  assign ent_e    = ent_q + ACC_W'(aterm);
  assign ent_c    = (ent_e > ONE_E) ? ONE_E : ((ent_e < -ONE_E) ? -ONE_E : ent_e);
  assign ent_m    = rnd_shift(ent_c, UNIT_FRAC - MAT_FRAC);

  assign busy = busy_r;
  assign mat  = mat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      busy_r     <= 1'b0;
      mat_r.status <= ST_OK;
      for (int k = 0; k < 9; k++) begin
        mat_r.m[k] <= (k % 4 == 0) ? MAT_W'(1 << MAT_FRAC) : '0;
      end
      ax_r       <= 1'b0;
      comp_r     <= '0;
      t_r        <= '0;
      e_r        <= '0;
      cnt_r      <= '0;
    end else if (go) begin
      state_r <= S_SQ_MUL;
      busy_r  <= 1'b1;
      ax_r    <= 1'b0;
      comp_r  <= '0;
      len2_r  <= '0;
    end else begin
      if (state_r == S_SQ_MUL || state_r == S_DOT_MUL || state_r == S_ENT_MUL) begin
        prod_r <= ACC_W'(mul_p);
      end
      unique case (state_r)
        S_IDLE: begin
          busy_r <= 1'b0;
        end
        S_SQ_MUL: begin
          state_r <= S_SQ_ACC;
        end
        S_SQ_ACC: begin
          len2_r <= len2_sum;
          if (comp_r == 2'd2) begin
            comp_r <= '0;
            if (len2_sum == '0) begin
              mat_r.status <= ST_ZERO_AXIS;
              busy_r       <= 1'b0;
              state_r      <= S_IDLE;
            end else begin
              x_r     <= len2_sum;
              root_r  <= '0;
              bit_r   <= ACC_W'(1) << (ACC_W - 2);
              cnt_r   <= 5'd31;
              state_r <= S_SQRT;
            end
          end else begin
            comp_r  <= comp_r + 2'd1;
            state_r <= S_SQ_MUL;
          end
        end
        S_SQRT: begin
          if (x_r >= root_bit) begin
            x_r    <= x_r - root_bit;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == '0) begin
            len_r   <= (x_r >= root_bit) ? 32'((root_r >> 1) + bit_r) : 32'(root_r >> 1);
            state_r <= S_U_GO;
          end
        end
        S_U_GO: begin
          state_r <= S_U_WAIT;
        end
        S_U_WAIT: begin
          if (div_done) begin
            if (ax_r) begin
              u2_r[comp_r] <= raw[AXIS_W-1] ? -$signed(div_quot[31:0])
                                           : $signed(div_quot[31:0]);
            end else begin
              u1_r[comp_r] <= raw[AXIS_W-1] ? -$signed(div_quot[31:0])
                                           : $signed(div_quot[31:0]);
            end
            if (comp_r == 2'd2) begin
              comp_r <= '0;
              if (!ax_r) begin
                ax_r    <= 1'b1;
                len2_r  <= '0;
                state_r <= S_SQ_MUL;
              end else begin
                t_r     <= '0;
                acc_r   <= '0;
                state_r <= S_DOT_MUL;
              end
            end else begin
              comp_r  <= comp_r + 2'd1;
              state_r <= S_U_GO;
            end
          end
        end
        S_DOT_MUL: begin
          state_r <= S_DOT_ACC;
        end
        S_DOT_ACC: begin
          if (t_r == 4'd2 || t_r == 4'd4 || t_r == 4'd6 || t_r == 4'd8) begin
            acc_r <= '0;
            case (t_r)
              4'd2:    c_r    <= dot_rnd[VEC_W-1:0];
              4'd4:    v_r[0] <= dot_rnd[VEC_W-1:0];
              4'd6:    v_r[1] <= dot_rnd[VEC_W-1:0];
              default: v_r[2] <= dot_rnd[VEC_W-1:0];
            endcase
          end else begin
            acc_r <= dot_sum;
          end
          if (t_r == 4'd8) begin
            if (d_w <= 0) begin
              mat_r.status <= ST_OPPOSITE;
              busy_r       <= 1'b0;
              state_r      <= S_IDLE;
            end else begin
              e_r     <= '0;
              state_r <= S_ENT_MUL;
            end
          end else begin
            t_r     <= t_r + 4'd1;
            state_r <= S_DOT_MUL;
          end
        end
        S_ENT_MUL: begin
          state_r <= S_ENT_GO;
        end
        S_ENT_GO: begin
          state_r <= S_ENT_WAIT;
        end
        S_ENT_WAIT: begin
          if (div_done) begin
            mat_r.m[e_r] <= ent_m[MAT_W-1:0];
            if (e_r == 4'd8) begin
              mat_r.status <= ST_OK;
              busy_r       <= 1'b0;
              state_r      <= S_IDLE;
            end else begin
              e_r     <= e_r + 4'd1;
              state_r <= S_ENT_MUL;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/aapr_point_pipe.sv =====
// ----------------------------------------------------------------------------
// aapr_point_pipe
// Four-stage point pipeline: capture, multiply, sum, round and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module aapr_point_pipe (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic [aapr_pkg::COORD_W-1:0] in_x,
  input  wire logic [aapr_pkg::COORD_W-1:0] in_y,
  input  wire logic [aapr_pkg::COORD_W-1:0] in_z,
  input  wire aapr_pkg::aapr_mat_t         mat,
  output logic                             out_valid,
  output logic [aapr_pkg::COORD_W-1:0]     out_x,
  output logic [aapr_pkg::COORD_W-1:0]     out_y,
  output logic [aapr_pkg::COORD_W-1:0]     out_z,
  output logic [1:0]                       out_status
);
  import aapr_pkg::*;

  localparam logic signed [ACC_W-1:0] CMAX = ACC_W'((64'd1 << (COORD_W - 1)) - 64'd1);
  localparam logic signed [ACC_W-1:0] CMIN = -CMAX - ACC_W'(1);

  logic                      s0_v_r, s1_v_r, s2_v_r, s3_v_r;
  logic signed [COORD_W-1:0] s0_p_r [3];
  logic signed [COORD_W-1:0] s1_p_r [3];
  logic signed [COORD_W-1:0] s2_p_r [3];
  logic signed [ACC_W-1:0]   s1_prod_r [9];
  logic signed [ACC_W-1:0]   s2_sum_r [3];
  logic [COORD_W-1:0]        s3_o_r [3];
  logic [1:0]                s3_st_r;

  logic signed [ACC_W-1:0]   prod_nxt [9];
  logic signed [ACC_W-1:0]   rnd [3];
  logic [COORD_W-1:0]        o_nxt [3];
  logic [2:0]                sat;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      prod_nxt[k] = $signed(mat.m[k]) * s0_p_r[k % 3];
    end
    for (int i = 0; i < 3; i++) begin
      rnd[i] = rnd_shift(s2_sum_r[i], MAT_FRAC);
      sat[i] = (rnd[i] > CMAX) || (rnd[i] < CMIN);
      if (mat.status != ST_OK) begin
        o_nxt[i] = s2_p_r[i];
      end else if (rnd[i] > CMAX) begin
        o_nxt[i] = CMAX[COORD_W-1:0];
      end else if (rnd[i] < CMIN) begin
        o_nxt[i] = CMIN[COORD_W-1:0];
      end else begin
        o_nxt[i] = rnd[i][COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s0_v_r <= in_valid;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
    if (in_valid) begin
      s0_p_r[0] <= in_x;
      s0_p_r[1] <= in_y;
      s0_p_r[2] <= in_z;
    end
    for (int k = 0; k < 9; k++) begin
      s1_prod_r[k] <= prod_nxt[k];
    end
    for (int i = 0; i < 3; i++) begin
      s1_p_r[i]   <= s0_p_r[i];
      s2_p_r[i]   <= s1_p_r[i];
      s2_sum_r[i] <= s1_prod_r[3*i] + s1_prod_r[3*i+1] + s1_prod_r[3*i+2];
      s3_o_r[i]   <= o_nxt[i];
    end
    if (mat.status != ST_OK) begin
      s3_st_r <= mat.status;
    end else begin
      s3_st_r <= (sat != '0) ? ST_SATURATED : ST_OK;
    end
  end

  assign out_valid  = s3_v_r;
  assign out_x      = s3_o_r[0];
  assign out_y      = s3_o_r[1];
  assign out_z      = s3_o_r[2];
  assign out_status = s3_st_r;

endmodule

`default_nettype wire

// ===== design/align_axis_point_rotator.sv =====
// ----------------------------------------------------------------------------
// align_axis_point_rotator
// Rotates Q16.16 points by the rotation carrying a source axis onto a target
// axis, with register port and matrix builder.
// ----------------------------------------------------------------------------
// One point is taken at every rising edge where start is high and busy is low,
// so points may follow back to back; each result passes the capture, multiply,
// sum and round/saturate stages of the four-stage point pipeline and then sits
// on the out_ ports with out_valid for one cycle; the receiver cannot stall it.
// After a write to an axis register the matrix is rebuilt by a shared
// multiplier, a bit-serial square root and a 64-step divider, while busy
// stays high.
`default_nettype none

module align_axis_point_rotator (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [aapr_pkg::COORD_W-1:0] in_pos_x,
  input  wire logic [aapr_pkg::COORD_W-1:0] in_pos_y,
  input  wire logic [aapr_pkg::COORD_W-1:0] in_pos_z,
  output logic                              out_valid,
  output logic [aapr_pkg::COORD_W-1:0]      out_rot_x,
  output logic [aapr_pkg::COORD_W-1:0]      out_rot_y,
  output logic [aapr_pkg::COORD_W-1:0]      out_rot_z,
  output logic [1:0]                        out_status,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [aapr_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [aapr_pkg::DATA_W-1:0]  pwdata,
  output logic [aapr_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);
  import aapr_pkg::*;

  aapr_axis_t axis_r;
  aapr_mat_t  mat;
  logic [2:0] idx;
  logic       wr;
  logic       bld_busy;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite && (idx < 3'(NUM_AXIS));
  assign pready = 1'b1;
  assign prdata = (idx < 3'(NUM_AXIS)) ? axis_r[idx] : '0;
  assign busy   = bld_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r[0] <= '0;
      axis_r[1] <= '0;
      axis_r[2] <= AXIS_W'(65536);
      axis_r[3] <= '0;
      axis_r[4] <= '0;
      axis_r[5] <= AXIS_W'(65536);
    end else if (wr) begin
      axis_r[idx] <= pwdata;
    end
  end

  aapr_mat_build u_build (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (wr),
    .axis  (axis_r),
    .busy  (bld_busy),
    .mat   (mat)
  );

  aapr_point_pipe u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (start && !bld_busy),
    .in_x       (in_pos_x),
    .in_y       (in_pos_y),
    .in_z       (in_pos_z),
    .mat        (mat),
    .out_valid  (out_valid),
    .out_x      (out_rot_x),
    .out_y      (out_rot_y),
    .out_z      (out_rot_z),
    .out_status (out_status)
  );

endmodule

`default_nettype wire
